>>> hw/rtl/rpl_pkg.sv
// Types and constants shared by the recency-ordered page list.
package rpl_pkg;

    localparam int PAGE_W        = 32;
    localparam int LIST_SIZE_W   = 5;
    localparam logic [LIST_SIZE_W-1:0] LIST_SIZE_RST = 5'd16;

    typedef enum logic [1:0] {
        REQ_PUSH_FRONT    = 2'd0,
        REQ_PUSH_BACK     = 2'd1,
        REQ_MOVE_FRONT    = 2'd2,
        REQ_REMOVE_BACK   = 2'd3
    } req_type_t;

    typedef struct packed {
        req_type_t          req_type;
        logic [PAGE_W-1:0]  page;
    } req_beat_t;

    typedef struct packed {
        logic               found;
        logic               dropped_valid;
        logic [PAGE_W-1:0]  dropped_page;
    } rsp_beat_t;

    typedef struct packed {
        logic       capture;
        logic       apply;
        req_type_t  req;
        logic       found;
    } cell_ctrl_t;

endpackage

>>> hw/rtl/rpl_req_if.sv
// Request channel: valid, ready and one request beat.
interface rpl_req_if;
    import rpl_pkg::*;

    logic      valid;
    logic      ready;
    req_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/rpl_rsp_if.sv
// Response channel: valid, ready and one response beat.
interface rpl_rsp_if;
    import rpl_pkg::*;

    logic      valid;
    logic      ready;
    rsp_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/rpl_cell.sv
// One slot of the list: page, full bit, match flag and neighbour shift logic.
module rpl_cell #(
    parameter int IDX   = 0,
    parameter int IDX_W = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rpl_pkg::cell_ctrl_t        ctrl,
    input  logic [IDX_W-1:0]           last_idx,
    input  logic [rpl_pkg::PAGE_W-1:0] bcast_page,
    input  logic [rpl_pkg::PAGE_W-1:0] prev_page,
    input  logic                       prev_full,
    input  logic [rpl_pkg::PAGE_W-1:0] next_page,
    input  logic                       next_full,
    input  logic                       hit_in,
    output logic                       hit_out,
    output logic [rpl_pkg::PAGE_W-1:0] page,
    output logic                       full
);
    import rpl_pkg::*;

    logic [PAGE_W-1:0] page_reg;
    logic [PAGE_W-1:0] page_next;
    logic              full_reg;
    logic              full_next;
    logic              match_reg;
    logic              match_next;
    logic              active;
    logic              is_first;
    logic              is_last;
    logic              hit_here;

    assign is_first = (IDX == 0);
    assign active   = (IDX_W'(IDX) <= last_idx);
    assign is_last  = (IDX_W'(IDX) == last_idx);
    assign hit_here = match_reg & active;
    assign hit_out  = hit_in | hit_here;
    assign page     = page_reg;
    assign full     = full_reg;

    always_comb
    begin
        match_next = match_reg;
        if (ctrl.capture)
        begin
            match_next = full_reg && (page_reg == bcast_page);
        end
    end

    always_comb
    begin
        page_next = page_reg;
        full_next = full_reg;
        if (ctrl.apply && active)
        begin
            unique case (ctrl.req)
                REQ_PUSH_FRONT:
                begin
                    if (is_first)
                    begin
                        page_next = bcast_page;
                        full_next = 1'b1;
                    end
                    else
                    begin
                        page_next = prev_page;
                        full_next = prev_full;
                    end
                end
                REQ_PUSH_BACK:
                begin
                    if (is_last)
                    begin
                        page_next = bcast_page;
                        full_next = 1'b1;
                    end
                    else
                    begin
                        page_next = next_page;
                        full_next = next_full;
                    end
                end
                REQ_MOVE_FRONT:
                begin
                    if (ctrl.found)
                    begin
                        if (is_first)
                        begin
                            page_next = bcast_page;
                            full_next = 1'b1;
                        end
                        else if (!hit_in)
                        begin
                            page_next = prev_page;
                            full_next = prev_full;
                        end
                    end
                end
                REQ_REMOVE_BACK:
                begin
                    if (ctrl.found && hit_out)
                    begin
                        if (is_last)
                        begin
                            page_next = '0;
                            full_next = 1'b0;
                        end
                        else
                        begin
                            page_next = next_page;
                            full_next = next_full;
                        end
                    end
                end
                default:
                begin
                    page_next = page_reg;
                    full_next = full_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg  <= page_next;
        match_reg <= match_next;
    end

endmodule

>>> hw/rtl/recency_ordered_page_list_core.sv
// Top level: request handling, size register, cell chain and response register.
// Each request has a compare step and an update step: in the cycle it is accepted every cell
// compares its page with the request, and then in state S_APPLY the hit ripples front to back
// along the cell chain while every cell in use loads itself or a neighbour. The
// response is held in an output register, and a new request is accepted while an
// earlier response still waits; the update stalls only while that register is
// still full and not read, and a new request is accepted only once the previous
// update is done. Slots at or beyond list_size (0 counts as 1, values above
// CAPACITY count as CAPACITY) keep their contents untouched.
module recency_ordered_page_list_core #(
    parameter int CAPACITY = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [rpl_pkg::LIST_SIZE_W-1:0] cfg_wr_data,
    rpl_req_if.sink                         request,
    rpl_rsp_if.source                       response
);
    import rpl_pkg::*;

    localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CAP_W   = $clog2(CAPACITY + 1);
    localparam int SZ_W    = (CAP_W > LIST_SIZE_W) ? CAP_W : LIST_SIZE_W;

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_APPLY = 1'b1;

    logic                   state_reg;
    logic                   state_next;
    logic [LIST_SIZE_W-1:0] list_size_reg;
    req_type_t              req_reg;
    logic [PAGE_W-1:0]      page_reg;
    logic                   rsp_valid_reg;
    logic                   rsp_valid_next;
    rsp_beat_t              rsp_data_reg;
    rsp_beat_t              rsp_data_next;

    logic                   accept;
    logic                   fire;
    logic [SZ_W-1:0]        size_ext;
    logic [SZ_W-1:0]        size_eff;
    logic [IDX_W-1:0]       last_idx;
    logic [IDX_W-1:0]       drop_idx;
    logic [PAGE_W-1:0]      bcast_page;
    cell_ctrl_t             ctrl;

    logic [PAGE_W-1:0]      cell_page [CAPACITY];
    logic                   cell_full [CAPACITY];
    logic                   hit_chain [CAPACITY+1];

    assign accept         = request.valid && request.ready;
    assign fire           = (state_reg == S_APPLY) && (!rsp_valid_reg || response.ready);
    assign request.ready  = (state_reg == S_IDLE);
    assign response.valid = rsp_valid_reg;
    assign response.data  = rsp_data_reg;

    always_comb
    begin
        size_ext = SZ_W'(list_size_reg);
        size_eff = size_ext;
        if (size_ext == '0)
        begin
            size_eff = SZ_W'(1);
        end
        else if (size_ext > SZ_W'(CAPACITY))
        begin
            size_eff = SZ_W'(CAPACITY);
        end
        last_idx = IDX_W'(size_eff - SZ_W'(1));
    end

    assign bcast_page   = (state_reg == S_IDLE) ? request.data.page : page_reg;
    assign hit_chain[0] = 1'b0;

    always_comb
    begin
        ctrl.capture = accept;
        ctrl.apply   = fire;
        ctrl.req     = req_reg;
        ctrl.found   = hit_chain[CAPACITY];
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam int PREV = (i == 0) ? 0 : i - 1;
        localparam int NEXT = (i == CAPACITY - 1) ? i : i + 1;

        rpl_cell #(
            .IDX   (i),
            .IDX_W (IDX_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .last_idx   (last_idx),
            .bcast_page (bcast_page),
            .prev_page  (cell_page[PREV]),
            .prev_full  (cell_full[PREV]),
            .next_page  (cell_page[NEXT]),
            .next_full  (cell_full[NEXT]),
            .hit_in     (hit_chain[i]),
            .hit_out    (hit_chain[i+1]),
            .page       (cell_page[i]),
            .full       (cell_full[i])
        );
    end

    assign drop_idx = (req_reg == REQ_PUSH_FRONT) ? last_idx : '0;

    always_comb
    begin
        rsp_data_next = rsp_data_reg;
        if (fire)
        begin
            rsp_data_next = '0;
            unique case (req_reg)
                REQ_PUSH_FRONT, REQ_PUSH_BACK:
                begin
                    rsp_data_next.dropped_valid = cell_full[drop_idx];
                    rsp_data_next.dropped_page  =
                        cell_full[drop_idx] ? cell_page[drop_idx] : '0;
                end
                REQ_MOVE_FRONT, REQ_REMOVE_BACK:
                begin
                    rsp_data_next.found = hit_chain[CAPACITY];
                end
                default:
                begin
                    rsp_data_next = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (response.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            list_size_reg <= LIST_SIZE_RST;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_wr_en)
            begin
                list_size_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
        if (accept)
        begin
            req_reg  <= request.data.req_type;
            page_reg <= request.data.page;
        end
    end

    a_hold_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !request.ready)
        else $error("request taken while previous one still in update");

    a_found_excl_drop: assert property (@(posedge clk) disable iff (!rst_n)
        response.valid |-> !(response.data.found && response.data.dropped_valid))
        else $error("response reports both a hit and a dropped slot");

    a_drop_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (response.valid && !response.data.dropped_valid) |->
            (response.data.dropped_page == '0))
        else $error("dropped page set without a dropped slot");

    a_front_full: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && hit_chain[CAPACITY] && (req_reg == REQ_MOVE_FRONT)) |=> cell_full[0])
        else $error("front slot empty after move to front");

endmodule

>>> tb/tb_recency_ordered_page_list_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the recency-ordered page list core.
module tb_recency_ordered_page_list_core;
    import rpl_pkg::*;

    localparam int CAPACITY       = 16;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 100;
    localparam int POOL_DEPTH     = 24;

    class page_list_scoreboard;
        logic [PAGE_W-1:0]      slot_page [CAPACITY];
        bit                     slot_used [CAPACITY];
        logic [LIST_SIZE_W-1:0] size_reg;
        rsp_beat_t              predicted_rsp_q [$];
        int                     errors;
        int                     checked;

        function new();
            foreach (slot_page[i])
            begin
                slot_page[i] = '0;
                slot_used[i] = 1'b0;
            end
            size_reg = LIST_SIZE_RST;
            errors   = 0;
            checked  = 0;
        endfunction

        function int span();
            if (size_reg == 0)
                return 1;
            if (size_reg > CAPACITY)
                return CAPACITY;
            return int'(size_reg);
        endfunction

        function void apply_request(req_beat_t beat);
            int        n;
            int        hit;
            int        drop;
            rsp_beat_t outcome;
            n       = span();
            outcome = '0;
            if (beat.req_type == REQ_PUSH_FRONT || beat.req_type == REQ_PUSH_BACK)
            begin
                drop = (beat.req_type == REQ_PUSH_FRONT) ? n - 1 : 0;
                if (slot_used[drop])
                begin
                    outcome.dropped_valid = 1'b1;
                    outcome.dropped_page  = slot_page[drop];
                end
                if (beat.req_type == REQ_PUSH_FRONT)
                begin
                    for (int i = n - 1; i > 0; i--)
                    begin
                        slot_page[i] = slot_page[i-1];
                        slot_used[i] = slot_used[i-1];
                    end
                    slot_page[0] = beat.page;
                    slot_used[0] = 1'b1;
                end
                else
                begin
                    for (int i = 0; i < n - 1; i++)
                    begin
                        slot_page[i] = slot_page[i+1];
                        slot_used[i] = slot_used[i+1];
                    end
                    slot_page[n-1] = beat.page;
                    slot_used[n-1] = 1'b1;
                end
            end
            else
            begin
                hit = n;
                for (int i = 0; i < n; i++)
                begin
                    if (hit == n && slot_used[i] && slot_page[i] == beat.page)
                        hit = i;
                end
                if (hit < n)
                begin
                    outcome.found = 1'b1;
                    if (beat.req_type == REQ_MOVE_FRONT)
                    begin
                        for (int i = hit; i > 0; i--)
                        begin
                            slot_page[i] = slot_page[i-1];
                            slot_used[i] = slot_used[i-1];
                        end
                        slot_page[0] = beat.page;
                        slot_used[0] = 1'b1;
                    end
                    else
                    begin
                        for (int i = hit; i < n - 1; i++)
                        begin
                            slot_page[i] = slot_page[i+1];
                            slot_used[i] = slot_used[i+1];
                        end
                        slot_page[n-1] = '0;
                        slot_used[n-1] = 1'b0;
                    end
                end
            end
            predicted_rsp_q = {predicted_rsp_q, outcome};
        endfunction

        function void check_response(rsp_beat_t seen);
            rsp_beat_t want;
            if (predicted_rsp_q.size() == 0)
            begin
                $display("%0t: unexpected response beat: found %0b dropped_valid %0b dropped_page %h",
                         $time, seen.found, seen.dropped_valid, seen.dropped_page);
                errors++;
                return;
            end
            want = predicted_rsp_q.pop_front();
            checked++;
            if (seen.found !== want.found)
            begin
                $display("%0t: found expected %0b actual %0b", $time, want.found, seen.found);
                errors++;
            end
            if (seen.dropped_valid !== want.dropped_valid)
            begin
                $display("%0t: dropped_valid expected %0b actual %0b",
                         $time, want.dropped_valid, seen.dropped_valid);
                errors++;
            end
            if (seen.dropped_page !== want.dropped_page)
            begin
                $display("%0t: dropped_page expected %h actual %h",
                         $time, want.dropped_page, seen.dropped_page);
                errors++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [LIST_SIZE_W-1:0] cfg_wr_data;

    rpl_req_if request_ch ();
    rpl_rsp_if response_ch ();

    page_list_scoreboard board = new();

    bit                     steady;
    int                     next_gap;
    int                     sent_count;
    int                     stall_cycles;
    int                     pool_span;
    logic [PAGE_W-1:0]      pool [POOL_DEPTH];
    logic [LIST_SIZE_W-1:0] phase_size [8] = '{5'd3, 5'd16, 5'd1, 5'd31, 5'd8, 5'd0, 5'd2, 5'd17};

    recency_ordered_page_list_core #(.CAPACITY(CAPACITY)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .request     (request_ch),
        .response    (response_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_req(req_type_t kind, logic [PAGE_W-1:0] pg);
        repeat (next_gap) @(posedge clk);
        request_ch.valid <= 1'b1;
        request_ch.data  <= '{req_type: kind, page: pg};
        do
            @(posedge clk);
        while (!request_ch.ready);
        sent_count++;
        next_gap = pick_gap();
        if (next_gap != 0)
            request_ch.valid <= 1'b0;
    endtask

    // Wait for every outstanding response before touching the size register.
    task automatic set_list_size(logic [LIST_SIZE_W-1:0] value);
        if (next_gap == 0)
            request_ch.valid <= 1'b0;
        while (board.checked != sent_count)
            @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en     <= 1'b0;
        board.size_reg = value;
        next_gap       = 0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && response_ch.valid && response_ch.ready)
            board.check_response(response_ch.data);
        if (rst_n && request_ch.valid && request_ch.ready)
            board.apply_request(request_ch.data);
    end

    always @(posedge clk)
    begin
        if ((request_ch.valid && request_ch.ready) || (response_ch.valid && response_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int unsigned hold;
        int          gap;
        response_ch.ready <= 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            hold = steady ? $urandom_range(50, 200) : $urandom_range(1, 12);
            response_ch.ready <= 1'b1;
            repeat (hold) @(posedge clk);
            gap = pick_gap();
            if (gap != 0)
            begin
                response_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    initial
    begin
        rst_n            <= 1'b0;
        cfg_wr_en        <= 1'b0;
        cfg_wr_data      <= '0;
        request_ch.valid <= 1'b0;
        request_ch.data  <= '0;
        steady     = 1'b0;
        next_gap   = 0;
        sent_count = 0;
        pool[0]    = '0;
        pool[1]    = '1;
        for (int i = 2; i < POOL_DEPTH; i++)
            pool[i] = $urandom();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Lookups on an empty list (page zero must miss empty slots), then pushes, moves and removes.
        send_req(REQ_MOVE_FRONT, 32'h0000_0000);
        send_req(REQ_REMOVE_BACK, 32'h0000_0000);
        send_req(REQ_PUSH_FRONT, 32'h0000_0000);
        send_req(REQ_PUSH_FRONT, 32'hFFFF_FFFF);
        send_req(REQ_PUSH_BACK, 32'h1234_5678);
        send_req(REQ_PUSH_FRONT, 32'hFFFF_FFFF);
        send_req(REQ_MOVE_FRONT, 32'hFFFF_FFFF);
        send_req(REQ_MOVE_FRONT, 32'h1234_5678);
        send_req(REQ_REMOVE_BACK, 32'h0000_0000);
        send_req(REQ_REMOVE_BACK, 32'hFFFF_FFFF);
        send_req(REQ_PUSH_BACK, 32'hA5A5_A5A5);
        send_req(REQ_PUSH_BACK, 32'h5A5A_5A5A);

        set_list_size(5'd1);
        send_req(REQ_PUSH_FRONT, 32'h0000_0007);
        send_req(REQ_PUSH_BACK, 32'h0000_0009);
        send_req(REQ_MOVE_FRONT, 32'h0000_0009);
        send_req(REQ_REMOVE_BACK, 32'h0000_0009);
        send_req(REQ_PUSH_FRONT, 32'h0000_0003);

        set_list_size(5'd0);
        send_req(REQ_PUSH_FRONT, 32'hFFFF_FFFF);
        send_req(REQ_PUSH_BACK, 32'h0000_0000);

        set_list_size(5'd31);
        send_req(REQ_PUSH_BACK, 32'h0000_0001);
        send_req(REQ_MOVE_FRONT, 32'h1234_5678);

        set_list_size(5'd2);
        send_req(REQ_PUSH_FRONT, 32'h0000_0011);
        send_req(REQ_PUSH_FRONT, 32'h0000_0022);
        send_req(REQ_PUSH_FRONT, 32'h0000_0033);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            set_list_size(ph < 8 ? phase_size[ph] : LIST_SIZE_W'($urandom_range(0, 31)));
            steady    = (ph % 4 == 3);
            pool_span = $urandom_range(2, POOL_DEPTH);
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_req(req_type_t'($urandom_range(0, 3)),
                         ($urandom_range(0, 9) == 0) ? $urandom()
                                                     : pool[$urandom_range(0, pool_span - 1)]);
        end

        if (next_gap == 0)
            request_ch.valid <= 1'b0;
        while (board.checked != sent_count)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (board.predicted_rsp_q.size() != 0)
        begin
            $display("%0t: %0d responses never arrived", $time, board.predicted_rsp_q.size());
            board.errors++;
        end
        if (board.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/rpl_pkg.sv
hw/rtl/rpl_req_if.sv
hw/rtl/rpl_rsp_if.sv
hw/rtl/rpl_cell.sv
hw/rtl/recency_ordered_page_list_core.sv
tb/tb_recency_ordered_page_list_core.sv
